FILE: hdl/blake256_hash_engine_top_assert.svh
// assertion macros for the blake-256 hash engine
`ifndef BLAKE256_HASH_ENGINE_TOP_ASSERT_SVH
`define BLAKE256_HASH_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define B256_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("b256 assertion failed");
`define B256_ASSERT_NEVER(lbl, cond) \
  `B256_ASSERT(lbl, !(cond))
`else
`define B256_ASSERT(lbl, prop)
`define B256_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hdl/b256_pkg.sv
// shared types, constants and tables for the blake-256 hash engine
package b256_pkg;

  localparam int B256_ROUNDS = 14;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] row_t;

  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    logic [1:0] lane;
    logic [7:0] wbyte;
    logic [3:0] raddr;
  } buf_ctl_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t PI [16] = '{
    32'h243f6a88, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
    32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89,
    32'h452821e6, 32'h38d01377, 32'hbe5466cf, 32'h34e90c6c,
    32'hc0ac29b7, 32'hc97c50dd, 32'h3f84d5b5, 32'hb5470917
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  function automatic logic [3:0] sigma_idx(logic [3:0] rm, logic [3:0] s);
    logic [3:0] res;
    if (rm > 4'd9) res = '0;
    else res = SIGMA[rm][s];
    return res;
  endfunction

  function automatic row_t rotl_row(row_t row, logic [1:0] amt);
    row_t res;
    for (int j = 0; j < 4; j++) begin
      res[j] = row[2'(j + int'(amt))];
    end
    return res;
  endfunction

endpackage

FILE: hdl/blake256_hash_engine_top.sv
// blake-256 hash engine top level: sequencer, state and round datapath
// each input word is accepted when idle, then written into the buffer byte by byte
// each full block is compressed as state init, ROUNDS rounds of half-g steps on
// the single half-g unit, then chain update; padding fills the block byte by byte,
// needs one or two compressions, then eight digest transfers at one per cycle if ready
// reset: chain value to the initial value, counters cleared, buffer untouched
`include "blake256_hash_engine_top_assert.svh"
module blake256_hash_engine_top #(
  parameter int ROUNDS = b256_pkg::B256_ROUNDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // message_word[31:0], byte_count[34:32], zero
  input  logic        s_axis_tlast_i,  // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // digest_word[31:0]
  output logic        m_axis_tlast_o   // last_digest_word
);
  import b256_pkg::*;

  localparam int RW = $clog2(ROUNDS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BYTE  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_CINIT = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_CFIN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state_q, state_d, ret_q, ret_d;
  word_t       word_q, word_d;
  logic [2:0]  cnt_q, cnt_d, k_q, k_d;
  logic        eom_q, eom_d, second_q, second_d;
  logic [6:0]  fill_q, fill_d;
  logic [63:0] bitcnt_q, bitcnt_d, total_q, total_d, comp_q, comp_d;
  logic [5:0]  pp_q, pp_d;
  logic [RW-1:0] r_q, r_d;
  logic [3:0]  rm_q, rm_d, s_q, s_d, rm_nx, s_nx;
  logic [2:0]  oi_q, oi_d;
  word_t       h_q [8];
  word_t       h_d [8];
  row_t        v_q [4];
  row_t        v_d [4];

  buf_ctl_t    ctl;
  word_t       msg, cst, na, nb, nc, nd;
  logic [7:0]  pad_byte;
  logic        fin;
  logic [2:0]  in_cnt;
  row_t        ra, rb, rc, rd;
  logic [1:0]  am, bm, cm, dm;
  logic        done_xfer;

  b256_msgbuf u_buf (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .rdata_o (msg)
  );

  b256_gunit u_g (
    .a_i    (v_q[0][0]),
    .b_i    (v_q[1][0]),
    .c_i    (v_q[2][0]),
    .d_i    (v_q[3][0]),
    .msg_i  (msg),
    .cst_i  (cst),
    .half_i (s_q[0]),
    .a_o    (na),
    .b_o    (nb),
    .c_o    (nc),
    .d_o    (nd)
  );

  assign cst    = PI[sigma_idx(rm_q, s_q ^ 4'd1)];
  assign in_cnt = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];
  assign fin    = (fill_q[5:0] <= 6'd55) || second_q;
  assign s_nx   = s_q + 4'd1;
  assign rm_nx  = (s_q != 4'd15) ? rm_q : ((rm_q == 4'd9) ? 4'd0 : rm_q + 4'd1);

  always_comb begin
    pad_byte = (pp_q == fill_q[5:0] && !second_q) ? 8'h80 : 8'h00;
    if (fin && pp_q == 6'd55) pad_byte = pad_byte | 8'h01;
    if (fin && pp_q >= 6'd56) pad_byte = total_q[{~pp_q[2:0], 3'b000} +: 8];
  end

  always_comb begin
    ctl.we    = 1'b0;
    ctl.waddr = state_q == S_PAD ? pp_q[5:2] : fill_q[5:2];
    ctl.lane  = state_q == S_PAD ? pp_q[1:0] : fill_q[1:0];
    ctl.wbyte = state_q == S_PAD ? pad_byte : word_q[{~k_q[1:0], 3'b000} +: 8];
    ctl.raddr = state_q == S_ROUND ? sigma_idx(rm_nx, s_nx) : sigma_idx(4'd0, 4'd0);
    if (state_q == S_PAD) ctl.we = 1'b1;
    if (state_q == S_BYTE && k_q < cnt_q) ctl.we = 1'b1;
  end

  always_comb begin
    case (s_q[3:1])
      3'd3:    begin am = 2'd1; bm = 2'd2; cm = 2'd3; dm = 2'd0; end
      3'd7:    begin am = 2'd1; bm = 2'd0; cm = 2'd3; dm = 2'd2; end
      default: begin am = 2'd1; bm = 2'd1; cm = 2'd1; dm = 2'd1; end
    endcase
    ra = v_q[0]; ra[0] = na;
    rb = v_q[1]; rb[0] = nb;
    rc = v_q[2]; rc[0] = nc;
    rd = v_q[3]; rd[0] = nd;
    if (s_q[0]) begin
      ra = rotl_row(ra, am);
      rb = rotl_row(rb, bm);
      rc = rotl_row(rc, cm);
      rd = rotl_row(rd, dm);
    end
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    eom_d    = eom_q;
    second_d = second_q;
    fill_d   = fill_q;
    bitcnt_d = bitcnt_q;
    total_d  = total_q;
    comp_d   = comp_q;
    pp_d     = pp_q;
    r_d      = r_q;
    rm_d     = rm_q;
    s_d      = s_q;
    oi_d     = oi_q;
    h_d      = h_q;
    v_d      = v_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          word_d  = s_axis_tdata_i[31:0];
          cnt_d   = in_cnt;
          eom_d   = s_axis_tlast_i;
          k_d     = '0;
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        if (k_q < cnt_q) begin
          k_d = k_q + 3'd1;
          if (fill_q[5:0] == 6'd63) begin
            fill_d   = '0;
            bitcnt_d = bitcnt_q + 64'd512;
            comp_d   = bitcnt_q + 64'd512;
            ret_d    = S_BYTE;
            state_d  = S_CINIT;
          end else begin
            fill_d = fill_q + 7'd1;
          end
        end else if (eom_q) begin
          total_d  = bitcnt_q + {55'd0, fill_q[5:0], 3'b000};
          pp_d     = fill_q[5:0];
          second_d = 1'b0;
          state_d  = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        pp_d = pp_q + 6'd1;
        if (pp_q == 6'd63) begin
          state_d = S_CINIT;
          if (fin) begin
            comp_d = (second_q || fill_q == 7'd0) ? 64'd0 : total_q;
            ret_d  = S_OUT;
          end else begin
            comp_d   = total_q;
            second_d = 1'b1;
            ret_d    = S_PAD;
          end
        end
      end
      S_CINIT: begin
        for (int j = 0; j < 4; j++) begin
          v_d[0][j] = h_q[j];
          v_d[1][j] = h_q[j + 4];
          v_d[2][j] = PI[j];
        end
        v_d[3][0] = PI[4] ^ comp_q[31:0];
        v_d[3][1] = PI[5] ^ comp_q[31:0];
        v_d[3][2] = PI[6] ^ comp_q[63:32];
        v_d[3][3] = PI[7] ^ comp_q[63:32];
        r_d     = '0;
        rm_d    = '0;
        s_d     = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        v_d[0] = ra;
        v_d[1] = rb;
        v_d[2] = rc;
        v_d[3] = rd;
        s_d    = s_nx;
        rm_d   = rm_nx;
        if (s_q == 4'd15) begin
          r_d = r_q + RW'(1);
          if (r_q == RW'(ROUNDS - 1)) state_d = S_CFIN;
        end
      end
      S_CFIN: begin
        for (int j = 0; j < 4; j++) begin
          h_d[j]     = h_q[j] ^ v_q[0][j] ^ v_q[2][j];
          h_d[j + 4] = h_q[j + 4] ^ v_q[1][j] ^ v_q[3][j];
        end
        state_d = ret_q;
        oi_d    = '0;
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          oi_d = oi_q + 3'd1;
          for (int j = 0; j < 7; j++) h_d[j] = h_q[j + 1];
          if (oi_q == 3'd7) begin
            h_d      = IV;
            bitcnt_d = '0;
            fill_d   = '0;
            state_d  = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      cnt_q    <= '0;
      k_q      <= '0;
      eom_q    <= 1'b0;
      second_q <= 1'b0;
      fill_q   <= '0;
      bitcnt_q <= '0;
      pp_q     <= '0;
      r_q      <= '0;
      rm_q     <= '0;
      s_q      <= '0;
      oi_q     <= '0;
      h_q      <= IV;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      eom_q    <= eom_d;
      second_q <= second_d;
      fill_q   <= fill_d;
      bitcnt_q <= bitcnt_d;
      pp_q     <= pp_d;
      r_q      <= r_d;
      rm_q     <= rm_d;
      s_q      <= s_d;
      oi_q     <= oi_d;
      h_q      <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    total_q <= total_d;
    comp_q  <= comp_d;
    v_q     <= v_d;
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = state_q == S_OUT;
  assign m_axis_tdata_o  = h_q[0];
  assign m_axis_tlast_o  = oi_q == 3'd7;
  assign done_xfer       = m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o;

  `B256_ASSERT_NEVER(a_sides_excl, s_axis_tready_o && m_axis_tvalid_o)
  `B256_ASSERT(a_fill_range, fill_q < 7'd64)
  `B256_ASSERT(a_round_range, (state_q == S_ROUND) |-> (r_q < RW'(ROUNDS)))
  `B256_ASSERT(a_done_clear, done_xfer |=> (bitcnt_q == '0 && fill_q == '0))

endmodule

FILE: hdl/b256_gunit.sv
// shared half-g mixing unit of the blake-256 round
module b256_gunit (
  input  b256_pkg::word_t a_i,
  input  b256_pkg::word_t b_i,
  input  b256_pkg::word_t c_i,
  input  b256_pkg::word_t d_i,
  input  b256_pkg::word_t msg_i,
  input  b256_pkg::word_t cst_i,
  input  logic            half_i,
  output b256_pkg::word_t a_o,
  output b256_pkg::word_t b_o,
  output b256_pkg::word_t c_o,
  output b256_pkg::word_t d_o
);
  import b256_pkg::*;

  word_t a1, dx, cx, d1, c1, bx;

  always_comb begin
    a1 = a_i + b_i + (msg_i ^ cst_i);
    dx = d_i ^ a1;
    d1 = half_i ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c1 = c_i + d1;
    cx = b_i ^ c1;
    bx = half_i ? {cx[6:0], cx[31:7]} : {cx[11:0], cx[31:12]};
  end

  assign a_o = a1;
  assign b_o = bx;
  assign c_o = c1;
  assign d_o = d1;

endmodule

FILE: hdl/b256_msgbuf.sv
// byte-writable 16-word block buffer with registered read
module b256_msgbuf (
  input  logic               clk_i,
  input  b256_pkg::buf_ctl_t ctl_i,
  output b256_pkg::word_t    rdata_o
);
  import b256_pkg::*;

  word_t mem_q [16];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr][{~ctl_i.lane, 3'b000} +: 8] <= ctl_i.wbyte;
    end
    rdata_q <= mem_q[ctl_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
